FILE: src/mpp_pkg.sv
package mpp_pkg;

    localparam logic [7:0] SyncByte = 8'h87;
    localparam logic [3:0] HdrNibble = 4'h8;
    localparam logic [3:0] BreakWindow = 4'd8;
    localparam logic [1:0] BaudReset = 2'd2;
    localparam int MaxResults = 3;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CfgDeviceOpen = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgOutputMode = 2'd1;

    typedef enum logic [2:0] {
        KIND_NATIVE = 3'd0,
        KIND_BUTTON = 3'd1,
        KIND_XDELTA = 3'd2,
        KIND_YDELTA = 3'd3,
        KIND_BAUD   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_X1   = 3'd1,
        PH_Y1   = 3'd2,
        PH_X2   = 3'd3,
        PH_Y2   = 3'd4,
        PH_HUNT = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        BTN_LEFT   = 2'd0,
        BTN_MIDDLE = 2'd1,
        BTN_RIGHT  = 2'd2
    } button_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  buttons_now;
        logic [2:0]  buttons_before;
        logic [7:0]  x_sum;
        logic [7:0]  y_sum;
        logic        break_pending;
        logic [3:0]  bytes_since_break;
        logic [1:0]  baud_now;
    } dec_state_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        raw_out;
        logic [1:0]        button_id;
        logic              pressed;
        logic signed [7:0] motion;
        logic [1:0]        baud_code;
        logic              last;
    } result_t;

    typedef struct packed {
        logic device_open;
        logic output_mode;
    } cfg_t;

endpackage

FILE: src/mpp_decode.sv
module mpp_decode (
    input  mpp_pkg::dec_state_t cur,
    input  mpp_pkg::cfg_t       cfg,
    input  logic [7:0]          rx_byte,
    input  logic                line_break,
    output mpp_pkg::dec_state_t nxt,
    output mpp_pkg::result_t    res [mpp_pkg::MaxResults],
    output logic [1:0]          res_count
);

    function automatic logic [7:0] clip_add(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0] s;
        s = $signed({a[7], a}) + $signed({b[7], b});
        if (s > 9'sd127) begin
            clip_add = 8'h7f;
        end else if (s < -9'sd127) begin
            clip_add = 8'h81;
        end else begin
            clip_add = s[7:0];
        end
    endfunction

    mpp_pkg::phase_t ph;
    logic            go;
    logic            done;
    logic [2:0]      diff;
    logic [1:0]      idx;

    always_comb begin
        nxt       = cur;
        ph        = cur.phase;
        go        = 1'b0;
        done      = 1'b0;
        diff      = 3'd0;
        idx       = 2'd0;
        res_count = 2'd0;
        for (int i = 0; i < mpp_pkg::MaxResults; i++) begin
            res[i] = '0;
        end

        if (line_break) begin
            if (!(cur.break_pending && cur.bytes_since_break < mpp_pkg::BreakWindow)) begin
                nxt.baud_now          = cur.baud_now + 2'd1;
                nxt.bytes_since_break = 4'd0;
                nxt.break_pending     = 1'b1;
                res[0].kind           = mpp_pkg::KIND_BAUD;
                res[0].baud_code      = cur.baud_now + 2'd1;
                res[0].last           = 1'b1;
                res_count             = 2'd1;
            end
        end else if (cur.break_pending) begin
            if (cur.bytes_since_break < mpp_pkg::BreakWindow) begin
                nxt.bytes_since_break = cur.bytes_since_break + 4'd1;
            end
            if (rx_byte == mpp_pkg::SyncByte) begin
                nxt.break_pending = 1'b0;
            end
        end else if (cfg.device_open) begin
            go = 1'b1;
            // sync byte found while hunting is taken as the header
            if (ph == mpp_pkg::PH_HUNT) begin
                if (rx_byte != mpp_pkg::SyncByte) begin
                    go = 1'b0;
                end else begin
                    ph = mpp_pkg::PH_HDR;
                end
            end
            if (go) begin
                case (ph)
                    mpp_pkg::PH_HDR: begin
                        if (rx_byte[7:4] == mpp_pkg::HdrNibble) begin
                            nxt.buttons_now = ~rx_byte[2:0];
                            if (rx_byte[3]) begin
                                nxt.phase = mpp_pkg::PH_X2;
                                nxt.x_sum = 8'd0;
                                nxt.y_sum = 8'd0;
                            end else begin
                                nxt.phase = mpp_pkg::PH_X1;
                            end
                        end else begin
                            nxt.phase = mpp_pkg::PH_HDR;
                        end
                    end
                    mpp_pkg::PH_X1: begin
                        nxt.x_sum = rx_byte;
                        nxt.phase = mpp_pkg::PH_Y1;
                    end
                    mpp_pkg::PH_Y1: begin
                        nxt.y_sum = rx_byte;
                        nxt.phase = mpp_pkg::PH_X2;
                    end
                    mpp_pkg::PH_X2: begin
                        nxt.x_sum = clip_add(cur.x_sum, rx_byte);
                        nxt.phase = mpp_pkg::PH_Y2;
                    end
                    mpp_pkg::PH_Y2: begin
                        nxt.y_sum = clip_add(cur.y_sum, rx_byte);
                        nxt.phase = mpp_pkg::PH_HDR;
                        done      = 1'b1;
                    end
                    default: begin
                        nxt.phase = mpp_pkg::PH_HUNT;
                    end
                endcase
            end

            if (done && !cfg.output_mode) begin
                res[0].raw_out = {5'b10000, ~cur.buttons_now};
                res[1].raw_out = cur.x_sum;
                res[2].raw_out = nxt.y_sum;
                res[2].last    = 1'b1;
                res_count      = 2'd3;
            end else if (done) begin
                diff               = cur.buttons_now ^ cur.buttons_before;
                nxt.buttons_before = cur.buttons_now;
                if (diff != 3'd0) begin
                    res[idx].kind = mpp_pkg::KIND_BUTTON;
                    // middle beats right, right beats left
                    if (diff[1]) begin
                        res[idx].button_id = mpp_pkg::BTN_MIDDLE;
                        res[idx].pressed   = cur.buttons_now[1];
                    end else if (diff[0]) begin
                        res[idx].button_id = mpp_pkg::BTN_RIGHT;
                        res[idx].pressed   = cur.buttons_now[0];
                    end else begin
                        res[idx].button_id = mpp_pkg::BTN_LEFT;
                        res[idx].pressed   = cur.buttons_now[2];
                    end
                    idx = idx + 2'd1;
                end
                if (cur.x_sum != 8'd0) begin
                    res[idx].kind   = mpp_pkg::KIND_XDELTA;
                    res[idx].motion = cur.x_sum;
                    nxt.x_sum       = 8'd0;
                    idx             = idx + 2'd1;
                end
                if (nxt.y_sum != 8'd0) begin
                    res[idx].kind   = mpp_pkg::KIND_YDELTA;
                    res[idx].motion = nxt.y_sum;
                    idx             = idx + 2'd1;
                end
                if (idx != 2'd0) begin
                    res[idx - 2'd1].last = 1'b1;
                end
                res_count = idx;
            end
        end
    end

endmodule

FILE: src/mouse_packet_parser.sv
// Mouse Systems style 5- or 3-byte packet decoder with break-driven baud stepping.
// Each received byte or break is decoded in the cycle it is accepted; its results
// (none to three) enter a 4-entry result queue and leave on the m_ channel one per
// cycle while m_ready is high, the first no earlier than the cycle after acceptance.
// s_ready is high while the queue holds at most one result, so one input
// transaction per cycle is taken while results drain; a byte that completes a
// packet produces up to three results, and the single output port then sets the
// pace at one result per cycle while m_ready is high: after a three-result
// transaction the input pauses, even with m_ready held high, until the queue is
// back to one result. Config writes (index 0 device_open, index 1 output_mode)
// are always ready and leave the decoder state untouched.
module mouse_packet_parser (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mpp_pkg::CfgIdxW-1:0] cfg_index,
    input  logic                        cfg_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    input  logic                        s_line_break,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_kind,
    output logic [7:0]                  m_raw_out,
    output logic [1:0]                  m_button_id,
    output logic                        m_pressed,
    output logic signed [7:0]           m_motion,
    output logic [1:0]                  m_baud_code,
    output logic                        m_last
);

    mpp_pkg::cfg_t       cfg_reg;
    mpp_pkg::dec_state_t state_reg;
    mpp_pkg::dec_state_t state_next;
    mpp_pkg::result_t    res [mpp_pkg::MaxResults];
    logic [1:0]          res_count;

    mpp_pkg::result_t    queue_reg [4];
    logic [1:0]          wr_ptr_reg;
    logic [1:0]          rd_ptr_reg;
    logic [2:0]          count_reg;

    logic                push;
    logic                pop;
    logic [1:0]          push_n;

    assign cfg_ready = 1'b1;
    assign s_ready   = (count_reg <= 3'd1);
    assign push      = s_valid && s_ready;
    assign pop       = m_valid && m_ready;
    assign push_n    = push ? res_count : 2'd0;

    mpp_decode u_decode (
        .cur        (state_reg),
        .cfg        (cfg_reg),
        .rx_byte    (s_rx_byte),
        .line_break (s_line_break),
        .nxt        (state_next),
        .res        (res),
        .res_count  (res_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == mpp_pkg::CfgDeviceOpen) begin
                cfg_reg.device_open <= cfg_data;
            end else if (cfg_index == mpp_pkg::CfgOutputMode) begin
                cfg_reg.output_mode <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase             <= mpp_pkg::PH_HUNT;
            state_reg.buttons_now       <= 3'd0;
            state_reg.buttons_before    <= 3'd0;
            state_reg.x_sum             <= 8'd0;
            state_reg.y_sum             <= 8'd0;
            state_reg.break_pending     <= 1'b0;
            state_reg.bytes_since_break <= 4'd0;
            state_reg.baud_now          <= mpp_pkg::BaudReset;
        end else if (push) begin
            state_reg <= state_next;
        end
    end

    // result queue: up to three writes per transaction, one read per cycle while m_ready is high
    always_ff @(posedge aclk) begin
        if (push) begin
            for (int i = 0; i < mpp_pkg::MaxResults; i++) begin
                if (2'(i) < res_count) begin
                    queue_reg[wr_ptr_reg + 2'(i)] <= res[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {1'b0, push_n} - {2'd0, pop};
        end
    end

    assign m_valid     = (count_reg != 3'd0);
    assign m_kind      = queue_reg[rd_ptr_reg].kind;
    assign m_raw_out   = queue_reg[rd_ptr_reg].raw_out;
    assign m_button_id = queue_reg[rd_ptr_reg].button_id;
    assign m_pressed   = queue_reg[rd_ptr_reg].pressed;
    assign m_motion    = queue_reg[rd_ptr_reg].motion;
    assign m_baud_code = queue_reg[rd_ptr_reg].baud_code;
    assign m_last      = queue_reg[rd_ptr_reg].last;

endmodule

FILE: tb/mouse_report_checker.sv
module mouse_report_checker (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [mpp_pkg::CfgIdxW-1:0] cfg_index,
    input  logic                        cfg_data,

    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    input  logic                        s_line_break,

    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [2:0]                  m_kind,
    input  logic [7:0]                  m_raw_out,
    input  logic [1:0]                  m_button_id,
    input  logic                        m_pressed,
    input  logic signed [7:0]           m_motion,
    input  logic [1:0]                  m_baud_code,
    input  logic                        m_last,

    output int                          mismatch_cnt,
    output int                          reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the registers and the decoder state
    logic            open_q;
    logic            cooked_q;
    mpp_pkg::phase_t ph;
    logic [2:0]      btn_now;
    logic [2:0]      btn_prev;
    logic [7:0]      x_acc;
    logic [7:0]      y_acc;
    logic            brk_pend;
    logic [3:0]      since_brk;
    logic [1:0]      baud;

    mpp_pkg::result_t exp_reports[$];
    int               bad_cnt;

    function automatic logic [7:0] sat_sum(input logic signed [7:0] a,
                                           input logic signed [7:0] b);
        int s;
        s = a + b;
        if (s > 127) s = 127;
        if (s < -127) s = -127;
        return s[7:0];
    endfunction

    task automatic decode_rx(input logic [7:0] rx, input logic brk);
        mpp_pkg::result_t fresh[$];
        mpp_pkg::result_t r;
        logic [2:0]       diff;
        if (brk) begin
            // a second break inside the window after an earlier one is swallowed
            if (brk_pend && since_brk < mpp_pkg::BreakWindow) return;
            baud = baud + 2'd1;
            since_brk = '0;
            brk_pend = 1'b1;
            r = '0;
            r.kind = mpp_pkg::KIND_BAUD;
            r.baud_code = baud;
            r.last = 1'b1;
            exp_reports.push_back(r);
            return;
        end
        if (brk_pend) begin
            if (since_brk < mpp_pkg::BreakWindow) since_brk++;
            if (rx == mpp_pkg::SyncByte) brk_pend = 1'b0;
            return;
        end
        if (!open_q) return;
        if (ph == mpp_pkg::PH_HUNT) begin
            if (rx != mpp_pkg::SyncByte) return;
            ph = mpp_pkg::PH_HDR;   // the sync byte is decoded as a header too
        end
        case (ph)
            mpp_pkg::PH_HDR: begin
                if (rx[7:4] != mpp_pkg::HdrNibble) return;
                btn_now = ~rx[2:0];
                if (rx[3]) begin
                    ph = mpp_pkg::PH_X2;
                    x_acc = '0;
                    y_acc = '0;
                end else begin
                    ph = mpp_pkg::PH_X1;
                end
                return;
            end
            mpp_pkg::PH_X1: begin
                x_acc = rx;
                ph = mpp_pkg::PH_Y1;
                return;
            end
            mpp_pkg::PH_Y1: begin
                y_acc = rx;
                ph = mpp_pkg::PH_X2;
                return;
            end
            mpp_pkg::PH_X2: begin
                x_acc = sat_sum(x_acc, rx);
                ph = mpp_pkg::PH_Y2;
                return;
            end
            mpp_pkg::PH_Y2: begin
                y_acc = sat_sum(y_acc, rx);
                ph = mpp_pkg::PH_HDR;
            end
            default: begin
                ph = mpp_pkg::PH_HUNT;
                return;
            end
        endcase

        if (!cooked_q) begin
            r = '0;
            r.kind = mpp_pkg::KIND_NATIVE;
            r.raw_out = {5'b10000, ~btn_now};
            fresh.push_back(r);
            r.raw_out = x_acc;
            fresh.push_back(r);
            r.raw_out = y_acc;
            fresh.push_back(r);
        end else begin
            diff = btn_now ^ btn_prev;
            btn_prev = btn_now;
            if (diff != 3'b000) begin
                r = '0;
                r.kind = mpp_pkg::KIND_BUTTON;
                // one event only: middle, then right, then left
                if (diff[1]) begin
                    r.button_id = mpp_pkg::BTN_MIDDLE;
                    r.pressed = btn_now[1];
                end else if (diff[0]) begin
                    r.button_id = mpp_pkg::BTN_RIGHT;
                    r.pressed = btn_now[0];
                end else begin
                    r.button_id = mpp_pkg::BTN_LEFT;
                    r.pressed = btn_now[2];
                end
                fresh.push_back(r);
            end
            if (x_acc != 8'h00) begin
                r = '0;
                r.kind = mpp_pkg::KIND_XDELTA;
                r.motion = x_acc;
                fresh.push_back(r);
                x_acc = '0;
            end
            if (y_acc != 8'h00) begin
                r = '0;
                r.kind = mpp_pkg::KIND_YDELTA;
                r.motion = y_acc;
                fresh.push_back(r);
            end
        end
        if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
        foreach (fresh[i]) exp_reports.push_back(fresh[i]);
    endtask

    task automatic check_report();
        mpp_pkg::result_t want;
        if (exp_reports.size() == 0) begin
            bad_cnt++;
            if (bad_cnt <= 10)
                $display({"%0t unexpected report: kind=%0d raw=%h btn=%0d prs=%0d",
                          " mot=%0d baud=%0d last=%0d"},
                         $time, m_kind, m_raw_out, m_button_id, m_pressed, m_motion,
                         m_baud_code, m_last);
            return;
        end
        want = exp_reports.pop_front();
        if (m_kind !== want.kind || m_raw_out !== want.raw_out ||
            m_button_id !== want.button_id || m_pressed !== want.pressed ||
            m_motion !== want.motion || m_baud_code !== want.baud_code ||
            m_last !== want.last) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
                $display("%0t report mismatch", $time);
                $display("  exp kind=%0d raw=%h btn=%0d prs=%0d mot=%0d baud=%0d last=%0d",
                         want.kind, want.raw_out, want.button_id, want.pressed, want.motion,
                         want.baud_code, want.last);
                $display("  got kind=%0d raw=%h btn=%0d prs=%0d mot=%0d baud=%0d last=%0d",
                         m_kind, m_raw_out, m_button_id, m_pressed, m_motion,
                         m_baud_code, m_last);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            open_q = 1'b0;
            cooked_q = 1'b0;
            ph = mpp_pkg::PH_HUNT;
            btn_now = '0;
            btn_prev = '0;
            x_acc = '0;
            y_acc = '0;
            brk_pend = 1'b0;
            since_brk = '0;
            baud = mpp_pkg::BaudReset;
            exp_reports.delete();
            bad_cnt = 0;
        end else begin
            // results of this edge's input cannot appear before the next edge
            if (m_valid && m_ready) check_report();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mpp_pkg::CfgDeviceOpen: open_q = cfg_data;
                    mpp_pkg::CfgOutputMode: cooked_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) decode_rx(s_rx_byte, s_line_break);
        end
        mismatch_cnt <= bad_cnt;
        reports_due <= exp_reports.size();
    end

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StuckLimit = 1000;
    localparam int LongHold = 60;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [mpp_pkg::CfgIdxW-1:0] cfg_index;
    logic                        cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic [7:0]                  s_rx_byte;
    logic                        s_line_break;
    logic                        m_valid;
    logic                        m_ready;
    logic [2:0]                  m_kind;
    logic [7:0]                  m_raw_out;
    logic [1:0]                  m_button_id;
    logic                        m_pressed;
    logic signed [7:0]           m_motion;
    logic [1:0]                  m_baud_code;
    logic                        m_last;

    int   mismatch_cnt;
    int   reports_due;
    logic quiet;
    int   hold_off_req;
    int   hold_off_seen = 0;
    int   long_left = 0;
    int   gap_left = 0;
    int   stuck_cycles = 0;

    mouse_packet_parser dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .s_line_break (s_line_break),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_raw_out    (m_raw_out),
        .m_button_id  (m_button_id),
        .m_pressed    (m_pressed),
        .m_motion     (m_motion),
        .m_baud_code  (m_baud_code),
        .m_last       (m_last)
    );

    mouse_report_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .s_line_break (s_line_break),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_raw_out    (m_raw_out),
        .m_button_id  (m_button_id),
        .m_pressed    (m_pressed),
        .m_motion     (m_motion),
        .m_baud_code  (m_baud_code),
        .m_last       (m_last),
        .mismatch_cnt (mismatch_cnt),
        .reports_due  (reports_due)
    );

    always #6ns aclk = ~aclk;

    // receiver: short random stalls, plus one long hold-off per request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_left > 0) begin
            long_left--;
            m_ready <= 1'b0;
        end else if (hold_off_seen != hold_off_req) begin
            hold_off_seen = hold_off_req;
            long_left = LongHold - 1;
            m_ready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= StuckLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic put_item(input logic [7:0] b, input logic brk);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        s_line_break <= brk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic put_byte(input logic [7:0] b);
        put_item(b, 1'b0);
    endtask

    task automatic put_break();
        put_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_packet(input logic [2:0] down, input logic skip_first,
                               input logic [7:0] x1, input logic [7:0] y1,
                               input logic [7:0] x2, input logic [7:0] y2);
        put_byte({mpp_pkg::HdrNibble, skip_first, ~down});
        if (!skip_first) begin
            put_byte(x1);
            put_byte(y1);
        end
        put_byte(x2);
        put_byte(y2);
    endtask

    function automatic logic [7:0] any_delta();
        case ($urandom_range(0, 6))
            0: return 8'h00;
            1: return 8'h7f;
            2: return 8'h80;
            3: return 8'h81;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // wait until every expected report is out and the decoder is quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic open_dev, input logic cooked);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= mpp_pkg::CfgDeviceOpen;
        cfg_data <= open_dev;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= mpp_pkg::CfgOutputMode;
        cfg_data <= cooked;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int goal);
        int   sent;
        int   pick;
        int   n;
        logic brief;
        sent = 0;
        while (sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if ($urandom_range(0, 3) == 0) begin
                    put_byte(mpp_pkg::SyncByte);
                    sent++;
                end
                brief = 1'($urandom_range(0, 1));
                send_packet(3'($urandom_range(0, 7)), brief, any_delta(), any_delta(),
                            any_delta(), any_delta());
                sent += brief ? 3 : 5;
            end else if (pick < 82) begin
                put_break();
                sent++;
                if ($urandom_range(0, 2) == 0) begin
                    put_break();
                    sent++;
                end
                n = $urandom_range(0, 10);
                repeat (n) put_byte(8'($urandom_range(0, 255)));
                sent += n;
                if (n >= 8 && $urandom_range(0, 1) == 0) begin
                    put_break();
                    sent++;
                end
                put_byte(mpp_pkg::SyncByte);
                sent++;
            end else if (pick < 92) begin
                put_byte(8'($urandom_range(0, 255)));
                sent++;
            end else begin
                // packet cut short, the rest gets misparsed until resync
                put_byte({mpp_pkg::HdrNibble, 1'b0, 3'($urandom_range(0, 7))});
                put_byte(any_delta());
                sent += 2;
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = mpp_pkg::CfgDeviceOpen;
        cfg_data = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'h00;
        s_line_break = 1'b0;
        quiet = 1'b0;
        hold_off_req = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // baud stepping and break window, device closed
        configure(1'b0, 1'b0);
        put_byte(mpp_pkg::SyncByte);
        put_break();
        put_break();            // inside window: swallowed
        put_byte(8'hff);
        put_byte(mpp_pkg::SyncByte);     // clears pending
        put_break();            // wraps the baud code to 0
        put_byte(8'h00);
        put_byte(8'hff);
        repeat (6) put_byte(8'($urandom_range(0, 8'h86)));
        put_break();            // window expired while still pending
        put_byte(mpp_pkg::SyncByte);

        // native stream: clipping both ways, short header, bad header
        configure(1'b1, 1'b0);
        send_packet(3'b000, 1'b0, 8'h7f, 8'h81, 8'h7f, 8'h80);
        send_packet(3'b101, 1'b1, 8'h00, 8'h00, 8'h05, 8'hfb);
        put_byte(8'h40);

        // cooked events: button priority and zero deltas
        configure(1'b1, 1'b1);
        send_packet(3'b111, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_packet(3'b000, 1'b1, 8'h00, 8'h00, 8'h03, 8'h00);
        send_packet(3'b101, 1'b1, 8'h00, 8'h00, 8'h00, 8'hfd);

        configure(1'b1, 1'b0);
        hold_off_req <= hold_off_req + 1;
        random_traffic(50);

        configure(1'b1, 1'b1);
        hold_off_req <= hold_off_req + 1;
        random_traffic(55);

        configure(1'b0, 1'b0);
        random_traffic(15);

        configure(1'b1, 1'b1);
        random_traffic(30);
        quiet <= 1'b1;
        random_traffic(25);

        settle();
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
